// File: hdl/raycast_text_column_defines.svh
// Assertion macros shared by the raycaster RTL.
`ifndef RAYCAST_TEXT_COLUMN_DEFINES_SVH
`define RAYCAST_TEXT_COLUMN_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define RTC_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("raycaster check failed");
// Check that a trigger is followed by a consequence in the next cycle.
`define RTC_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("raycaster sequence check failed");
`else
`define RTC_ASSERT(label, cond)
`define RTC_ASSERT_NEXT(label, trig, cons)
`endif
`endif

// File: hdl/rtc_pkg.sv
// Shared types, constants and helpers of the text-column raycaster.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 24;
   localparam int MARCH_LIMIT    = 1000;

   localparam int ANG_W     = 32;
   localparam int POS_W     = 28;
   localparam int DIST_W    = 27;
   localparam int CORR_W    = 28;
   localparam int DIV_BITS  = 8;
   localparam int REM_W     = 24;
   localparam int ROW_CNT_W = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
   localparam int HGT_W     = $clog2(SCREEN_ROWS + 1);
   localparam int CNT_W     = ($clog2(MARCH_LIMIT + 1) > 3) ? $clog2(MARCH_LIMIT + 1) : 3;
   localparam int WRAP_STEPS = 2 + 128 / (6 * SCREEN_COLUMNS);

   localparam logic signed [ANG_W-1:0] PI_Q20      = 32'sd3294196;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q20  = 32'sd6588392;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 32'sd1647093;
   localparam logic signed [ANG_W-1:0] HALF_Q20    = 32'sd524288;
   localparam logic [31:0] STEP_Q20     = 32'd20972;
   localparam logic [CORR_W-1:0] MIN_DIST_Q20 = 28'd104858;
   localparam logic [REM_W-1:0] HEIGHT_NUM = 24'd15728640;
   localparam logic [DIST_W-1:0] NEAR_Q20 = 27'd3145728;
   localparam logic [DIST_W-1:0] MID_Q20  = 27'd6291456;

   // reciprocals for the constant divisions
   localparam logic [63:0] COL_RECIP =
      ((64'd1 << 44) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);
   localparam logic [31:0] RECIP_6   = 32'd178956971;
   localparam logic [31:0] RECIP_120 = 32'd1145324613;

   localparam logic [1:0] GLYPH_CEIL  = 2'd0;
   localparam logic [1:0] GLYPH_WALL  = 2'd1;
   localparam logic [1:0] GLYPH_FLOOR = 2'd2;
   localparam logic [7:0] ATTR_CEIL  = 8'h18;
   localparam logic [7:0] ATTR_FLOOR = 8'h02;
   localparam logic [7:0] ATTR_NEAR  = 8'h0F;
   localparam logic [7:0] ATTR_MID   = 8'h07;
   localparam logic [7:0] ATTR_FAR   = 8'h08;

   localparam logic [1:0] SEL_COS_RA  = 2'd0;
   localparam logic [1:0] SEL_SIN_RA  = 2'd1;
   localparam logic [1:0] SEL_COS_OFS = 2'd2;

   typedef struct packed {
      logic                 load;
      logic                 ofs;
      logic                 sin_start;
      logic [1:0]           sin_sel;
      logic                 trig_cap;
      logic                 march_init;
      logic                 march_step;
      logic                 march_done;
      logic                 corr;
      logic                 div_step;
      logic [2:0]           div_bit;
      logic                 height;
      logic [ROW_CNT_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic sin_done;
      logic stop_out;
      logic stop_wall;
   } status_type;

   // Q2.14 trig value times the march step, truncated toward zero to Q.20
   function automatic logic signed [POS_W-1:0] step_comp(input logic signed [15:0] c);
      logic        neg;
      logic [15:0] mag;
      logic [31:0] p;
      neg = c[15];
      mag = neg ? 16'(-c) : 16'(c);
      p   = (32'(mag) * STEP_Q20) >> 14;
      return neg ? -POS_W'(p) : POS_W'(p);
   endfunction
endpackage
`default_nettype wire

// File: hdl/raycast_text_column.sv
// Top level of the text-column raycaster.
//
// One request word carries a screen column and the player's position and heading.
// The block casts one ray over the 16x16 wall bitmap and answers with 24 response
// words, one text cell per row, top row first; tlast marks the bottom row.
// The wall bitmap is written through the csr_ APB port, four 64-bit registers at
// byte addresses 0, 8, 16 and 24. The user must write it only while no column is
// in flight; the block itself leaves this unchecked.
// Steps: the column offset, then three sine evaluations on one shared multiplier,
// one march step per cycle up to 1000 steps, then a stop, the distance correction
// and the 8-step height division, then one row per cycle while the receiver accepts.
// One column is worked on at a time: req_tready is high only between columns.
// When the receiver stalls, the current cell holds on rsp_tdata until it is taken.
// Reset is synchronous: it returns the sequencer to idle and clears the bitmap.
`timescale 1ns / 1ps
`default_nettype none
module raycast_text_column (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // column[6:0], player_x[22:7], player_y[38:23], view_angle[54:39], zero pad[55]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // row[4:0], glyph[6:5], attribute[14:7], wall_hit[15]
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   rtc_pkg::cmd_type    cmd;
   rtc_pkg::status_type status;
   logic       cfg_we;
   logic [4:0] row;
   logic [1:0] glyph;
   logic [7:0] attribute;
   logic       wall_hit;
   logic       last_cell;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;

   rtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rtc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .column     (req_tdata[6:0]),
      .player_x   (req_tdata[22:7]),
      .player_y   (req_tdata[38:23]),
      .view_angle (req_tdata[54:39]),
      .cmd        (cmd),
      .status     (status),
      .cfg_we     (cfg_we),
      .cfg_idx    (csr_paddr[4:3]),
      .cfg_wdata  (csr_pwdata),
      .cfg_rdata  (csr_prdata),
      .row        (row),
      .glyph      (glyph),
      .attribute  (attribute),
      .wall_hit   (wall_hit),
      .last_cell  (last_cell)
   );

   assign rsp_tdata = {wall_hit, attribute, glyph, row};
   assign rsp_tlast = last_cell;
endmodule
`default_nettype wire

// File: hdl/rtc_sin.sv
// Multi-cycle polynomial sine unit with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
`include "raycast_text_column_defines.svh"
module rtc_sin (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [rtc_pkg::ANG_W-1:0]  angle,
   output logic                                   done,
   output logic signed [15:0]                     result
);
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_A2   = 3'd1;
   localparam logic [2:0] PH_A3   = 3'd2;
   localparam logic [2:0] PH_A5   = 3'd3;
   localparam logic [2:0] PH_T3   = 3'd4;
   localparam logic [2:0] PH_T5   = 3'd5;
   localparam logic [2:0] PH_SUM  = 3'd6;

   logic [2:0]  ph_ff, ph_in;
   logic        done_ff;
   logic        neg_ff;
   logic [21:0] a_ff;
   logic [23:0] a2_ff;
   logic [24:0] a3_ff;
   logic [28:0] a5_ff;
   logic [24:0] t3_ff;
   logic [28:0] t5_ff;
   logic signed [15:0] res_ff;

   logic signed [rtc_pkg::ANG_W-1:0] wrap;
   logic signed [rtc_pkg::ANG_W-1:0] mag;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [29:0] sum;
   logic [15:0] q;

   // fold the angle into -pi..pi
   always_comb begin
      wrap = angle;
      for (int i = 0; i < rtc_pkg::WRAP_STEPS; i++) begin
         if (wrap > rtc_pkg::PI_Q20) begin
            wrap = wrap - rtc_pkg::TWO_PI_Q20;
         end else if (wrap < -rtc_pkg::PI_Q20) begin
            wrap = wrap + rtc_pkg::TWO_PI_Q20;
         end
      end
      mag = wrap[rtc_pkg::ANG_W-1] ? -wrap : wrap;
   end

   always_comb begin
      case (ph_ff)
         PH_A2: begin ma = 32'(a_ff);  mb = 32'(a_ff);  end
         PH_A3: begin ma = 32'(a2_ff); mb = 32'(a_ff);  end
         PH_A5: begin ma = 32'(a3_ff); mb = 32'(a2_ff); end
         PH_T3: begin ma = 32'(a3_ff); mb = rtc_pkg::RECIP_6;   end
         PH_T5: begin ma = 32'(a5_ff); mb = rtc_pkg::RECIP_120; end
         default: begin ma = '0; mb = '0; end
      endcase
      prod = 64'(ma) * 64'(mb);
      sum  = 30'(a_ff) - 30'(t3_ff) + 30'(t5_ff);
      q    = 16'(sum >> 6);
   end

   always_comb begin
      case (ph_ff)
         PH_IDLE: ph_in = start ? PH_A2 : PH_IDLE;
         PH_A2:   ph_in = PH_A3;
         PH_A3:   ph_in = PH_A5;
         PH_A5:   ph_in = PH_T3;
         PH_T3:   ph_in = PH_T5;
         PH_T5:   ph_in = PH_SUM;
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= (ph_ff == PH_SUM);
      end
   end

   always_ff @(posedge clock) begin
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               neg_ff <= wrap[rtc_pkg::ANG_W-1];
               a_ff   <= 22'(mag);
            end
         end
         PH_A2: a2_ff <= 24'(prod >> 20);
         PH_A3: a3_ff <= 25'(prod >> 20);
         PH_A5: a5_ff <= 29'(prod >> 20);
         PH_T3: t3_ff <= 25'(prod >> 30);
         PH_T5: t5_ff <= 29'(prod >> 37);
         PH_SUM: res_ff <= neg_ff ? -$signed(q) : $signed(q);
         default: begin end
      endcase
   end

   assign done   = done_ff;
   assign result = res_ff;

   `RTC_ASSERT_NEXT(a_done_single, done_ff, !done_ff)
   `RTC_ASSERT(a_start_idle, !(start && ph_ff != PH_IDLE))
   `RTC_ASSERT(a_phase_legal, ph_ff <= PH_SUM)
endmodule
`default_nettype wire

// File: hdl/rtc_dp.sv
// Raycaster datapath: angles, trig, march, distance, division and cell coding.
`timescale 1ns / 1ps
`default_nettype none
module rtc_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [6:0]           column,
   input  wire logic [15:0]          player_x,
   input  wire logic [15:0]          player_y,
   input  wire logic signed [15:0]   view_angle,
   input  wire rtc_pkg::cmd_type     cmd,
   output rtc_pkg::status_type       status,
   input  wire logic                 cfg_we,
   input  wire logic [1:0]           cfg_idx,
   input  wire logic [63:0]          cfg_wdata,
   output logic [63:0]               cfg_rdata,
   output logic [4:0]                row,
   output logic [1:0]                glyph,
   output logic [7:0]                attribute,
   output logic                      wall_hit,
   output logic                      last_cell
);
   logic [63:0] wall0_ff, wall1_ff, wall2_ff, wall3_ff;
   logic [6:0]  col_ff;
   logic [15:0] px_ff, py_ff;
   logic signed [15:0] pa_ff;
   logic signed [rtc_pkg::ANG_W-1:0] ofs_ff;
   logic signed [rtc_pkg::POS_W-1:0] ddx_ff, ddy_ff, ex_ff, ey_ff;
   logic signed [15:0] cosofs_ff;
   logic [rtc_pkg::DIST_W-1:0] dist_ff;
   logic        hit_ff;
   logic [rtc_pkg::CORR_W-1:0] corr_ff;
   logic [rtc_pkg::REM_W-1:0]  rem_ff;
   logic [rtc_pkg::DIV_BITS-1:0] q_ff;
   logic [rtc_pkg::HGT_W-1:0] ds_ff, de_ff;
   logic [7:0]  wattr_ff;

   logic [51:0] col_prod;
   logic signed [rtc_pkg::ANG_W-1:0] ra, sin_angle;
   logic        sin_start, sin_done;
   logic signed [15:0] sin_res;
   logic        outside;
   logic [3:0]  ix, iy;
   logic [63:0] map_row;
   logic        cell_bit;
   logic [15:0] cos_mag;
   logic [41:0] corr_prod;
   logic [rtc_pkg::CORR_W-1:0] corr_val;
   logic [34:0] trial;
   logic [rtc_pkg::HGT_W-1:0] h;
   logic [rtc_pkg::HGT_W-1:0] row_w;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wall0_ff <= '0;
         wall1_ff <= '0;
         wall2_ff <= '0;
         wall3_ff <= '0;
      end else if (cfg_we) begin
         case (cfg_idx)
            2'd0: wall0_ff <= cfg_wdata;
            2'd1: wall1_ff <= cfg_wdata;
            2'd2: wall2_ff <= cfg_wdata;
            default: wall3_ff <= cfg_wdata;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         2'd0: cfg_rdata = wall0_ff;
         2'd1: cfg_rdata = wall1_ff;
         2'd2: cfg_rdata = wall2_ff;
         default: cfg_rdata = wall3_ff;
      endcase
   end

   always_comb begin
      col_prod = 52'(col_ff) * 52'(rtc_pkg::COL_RECIP);
      ra = $signed({{(rtc_pkg::ANG_W-24){pa_ff[15]}}, pa_ff, 8'h00}) + ofs_ff;
      case (cmd.sin_sel)
         rtc_pkg::SEL_COS_RA: sin_angle = ra + rtc_pkg::HALF_PI_Q20;
         rtc_pkg::SEL_SIN_RA: sin_angle = ra;
         default:             sin_angle = ofs_ff + rtc_pkg::HALF_PI_Q20;
      endcase
   end

   assign sin_start = cmd.sin_start;

   rtc_sin u_sin (
      .clock  (clock),
      .reset  (reset),
      .start  (sin_start),
      .angle  (sin_angle),
      .done   (sin_done),
      .result (sin_res)
   );

   // map lookup on the current march position
   always_comb begin
      ix = ex_ff[23:20];
      iy = ey_ff[23:20];
      outside = ex_ff[rtc_pkg::POS_W-1] || ey_ff[rtc_pkg::POS_W-1] ||
                (ex_ff[rtc_pkg::POS_W-2:24] != '0) || (ey_ff[rtc_pkg::POS_W-2:24] != '0);
      case (iy[3:2])
         2'd0: map_row = wall0_ff;
         2'd1: map_row = wall1_ff;
         2'd2: map_row = wall2_ff;
         default: map_row = wall3_ff;
      endcase
      cell_bit = map_row[{iy[1:0], ix}];
      status.sin_done  = sin_done;
      status.stop_out  = outside;
      status.stop_wall = !outside && cell_bit;
   end

   always_comb begin
      cos_mag   = cosofs_ff[15] ? 16'(-cosofs_ff) : 16'(cosofs_ff);
      corr_prod = (42'(dist_ff) * 42'(cos_mag)) >> 14;
      corr_val  = rtc_pkg::CORR_W'(corr_prod);
      trial     = 35'(corr_ff) << cmd.div_bit;
      if (!hit_ff) begin
         h = '0;
      end else if (q_ff > rtc_pkg::DIV_BITS'(rtc_pkg::SCREEN_ROWS)) begin
         h = rtc_pkg::HGT_W'(rtc_pkg::SCREEN_ROWS);
      end else begin
         h = rtc_pkg::HGT_W'(q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= column;
         px_ff  <= player_x;
         py_ff  <= player_y;
         pa_ff  <= view_angle;
      end
      if (cmd.ofs) begin
         ofs_ff <= rtc_pkg::ANG_W'(col_prod >> 24) - rtc_pkg::HALF_Q20;
      end
      if (cmd.trig_cap) begin
         case (cmd.sin_sel)
            rtc_pkg::SEL_COS_RA: ddx_ff <= rtc_pkg::step_comp(sin_res);
            rtc_pkg::SEL_SIN_RA: ddy_ff <= rtc_pkg::step_comp(sin_res);
            default:             cosofs_ff <= sin_res;
         endcase
      end
      if (cmd.march_init) begin
         ex_ff   <= $signed({{(rtc_pkg::POS_W-24){1'b0}}, px_ff, 8'h00});
         ey_ff   <= $signed({{(rtc_pkg::POS_W-24){1'b0}}, py_ff, 8'h00});
         dist_ff <= '0;
      end else if (cmd.march_step) begin
         ex_ff   <= ex_ff + ddx_ff;
         ey_ff   <= ey_ff + ddy_ff;
         dist_ff <= dist_ff + rtc_pkg::DIST_W'(rtc_pkg::STEP_Q20);
      end
      if (cmd.march_done) begin
         hit_ff <= status.stop_wall;
      end
      if (cmd.corr) begin
         if (cosofs_ff[15] || corr_val < rtc_pkg::MIN_DIST_Q20) begin
            corr_ff <= rtc_pkg::MIN_DIST_Q20;
         end else begin
            corr_ff <= corr_val;
         end
         rem_ff <= rtc_pkg::HEIGHT_NUM;
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (35'(rem_ff) >= trial) begin
            rem_ff <= rem_ff - rtc_pkg::REM_W'(trial);
            q_ff[cmd.div_bit] <= 1'b1;
         end
      end
      if (cmd.height) begin
         ds_ff <= (rtc_pkg::HGT_W'(rtc_pkg::SCREEN_ROWS) - h) >> 1;
         de_ff <= ((rtc_pkg::HGT_W'(rtc_pkg::SCREEN_ROWS) - h) >> 1) + h;
         if (dist_ff < rtc_pkg::NEAR_Q20) begin
            wattr_ff <= rtc_pkg::ATTR_NEAR;
         end else if (dist_ff < rtc_pkg::MID_Q20) begin
            wattr_ff <= rtc_pkg::ATTR_MID;
         end else begin
            wattr_ff <= rtc_pkg::ATTR_FAR;
         end
      end
   end

   // cell coding for the row under emission
   always_comb begin
      row_w = rtc_pkg::HGT_W'(cmd.row);
      row   = 5'(cmd.row);
      if (row_w < ds_ff) begin
         glyph     = rtc_pkg::GLYPH_CEIL;
         attribute = rtc_pkg::ATTR_CEIL;
      end else if (row_w < de_ff) begin
         glyph     = rtc_pkg::GLYPH_WALL;
         attribute = wattr_ff;
      end else begin
         glyph     = rtc_pkg::GLYPH_FLOOR;
         attribute = rtc_pkg::ATTR_FLOOR;
      end
      wall_hit  = hit_ff;
      last_cell = (cmd.row == rtc_pkg::ROW_CNT_W'(rtc_pkg::SCREEN_ROWS - 1));
   end
endmodule
`default_nettype wire

// File: hdl/rtc_ctrl.sv
// Raycaster sequencer: steps the datapath through trig, march, divide and emit.
`timescale 1ns / 1ps
`default_nettype none
`include "raycast_text_column_defines.svh"
module rtc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire rtc_pkg::status_type status,
   output rtc_pkg::cmd_type         cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_OFS      = 4'd1;
   localparam logic [3:0] S_SIN_GO   = 4'd2;
   localparam logic [3:0] S_SIN_WAIT = 4'd3;
   localparam logic [3:0] S_MARCH    = 4'd4;
   localparam logic [3:0] S_CORR     = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_HGT      = 4'd7;
   localparam logic [3:0] S_EMIT     = 4'd8;

   localparam logic [rtc_pkg::ROW_CNT_W-1:0] LAST_ROW =
      rtc_pkg::ROW_CNT_W'(rtc_pkg::SCREEN_ROWS - 1);

   logic [3:0] state_ff, state_in;
   logic [rtc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [rtc_pkg::ROW_CNT_W-1:0] row_ff, row_in;
   logic [1:0] sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sin_sel = sel_ff;
      cmd.row     = row_ff;
      cmd.div_bit = cnt_ff[2:0];
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_OFS;
            end
         end
         S_OFS: begin
            cmd.ofs  = 1'b1;
            sel_in   = rtc_pkg::SEL_COS_RA;
            state_in = S_SIN_GO;
         end
         S_SIN_GO: begin
            cmd.sin_start = 1'b1;
            state_in = S_SIN_WAIT;
         end
         S_SIN_WAIT: begin
            if (status.sin_done) begin
               cmd.trig_cap = 1'b1;
               if (sel_ff == rtc_pkg::SEL_COS_OFS) begin
                  cmd.march_init = 1'b1;
                  cnt_in   = '0;
                  state_in = S_MARCH;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = S_SIN_GO;
               end
            end
         end
         S_MARCH: begin
            // check the position reached by the last step before taking another
            if (cnt_ff != '0 && (status.stop_out || status.stop_wall)) begin
               cmd.march_done = 1'b1;
               state_in = S_CORR;
            end else if (cnt_ff == rtc_pkg::CNT_W'(rtc_pkg::MARCH_LIMIT)) begin
               cmd.march_done = 1'b1;
               state_in = S_CORR;
            end else begin
               cmd.march_step = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CORR: begin
            cmd.corr = 1'b1;
            cnt_in   = rtc_pkg::CNT_W'(rtc_pkg::DIV_BITS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_HGT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_HGT: begin
            cmd.height = 1'b1;
            row_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (row_ff == LAST_ROW) begin
                  state_in = S_IDLE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         sel_ff   <= sel_in;
      end
   end

   `RTC_ASSERT(a_one_side, !(req_ready && rsp_valid))
   `RTC_ASSERT_NEXT(a_last_to_idle, rsp_valid && rsp_ready && row_ff == LAST_ROW,
                    state_ff == S_IDLE)
   `RTC_ASSERT(a_march_bound,
               !(state_ff == S_MARCH && cnt_ff > rtc_pkg::CNT_W'(rtc_pkg::MARCH_LIMIT)))
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the text-column raycaster.
`timescale 1ns / 1ps
module testbench;
   typedef struct {
      logic [4:0] row;
      logic [1:0] glyph;
      logic [7:0] attribute;
      logic       wall_hit;
      logic       last_cell;
   } cell_type;

   typedef struct {
      logic [6:0]  column;
      logic [15:0] player_x;
      logic [15:0] player_y;
      logic [15:0] view_angle;
   } column_req_type;

   localparam int MAP_SIZE = 16;
   localparam longint Q_ONE = 64'sd1 << 20;
   localparam longint MIN_DIST = 104858;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   raycast_text_column dut (.*);

   always #5 clock = ~clock;

   logic [63:0]    wall_map [4];
   column_req_type pending_cols[$];
   cell_type       expected_cells[$];
   int             error_count = 0;
   int             cells_seen = 0;
   int             hit_columns = 0;
   int             cols_sent = 0;

   function automatic longint ray_sine(longint ang);
      longint unsigned mag, a2, a3, a5, s;
      bit neg;
      while (ang > 3294196) ang -= 6588392;
      while (ang < -3294196) ang += 6588392;
      neg = ang < 0;
      mag = neg ? -ang : ang;
      a2 = (mag * mag) >> 20;
      a3 = (a2 * mag) >> 20;
      a5 = (a3 * a2) >> 20;
      s = mag - a3 / 6 + a5 / 120;
      return neg ? -longint'(s >> 6) : longint'(s >> 6);
   endfunction

   function automatic longint scale_trunc(longint a, longint b, int sh);
      longint unsigned ma, mb, m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m = (ma * mb) >> sh;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic bit map_wall(int ix, int iy);
      return wall_map[iy >> 2][(iy & 3) * 16 + ix];
   endfunction

   // Cast one ray and queue the 24 cells of its column.
   task automatic cast_column(column_req_type c);
      longint offset, ra, ddx, ddy, ex, ey, travel, corr, h, ds, de;
      logic [7:0] wall_attr;
      bit hit;
      cell_type cl;
      offset = -524288 + longint'((longint'(c.column) << 20) / rtc_pkg::SCREEN_COLUMNS);
      ra = longint'($signed(c.view_angle)) * 256 + offset;
      ddx = scale_trunc(ray_sine(ra + 1647093), 20972, 14);
      ddy = scale_trunc(ray_sine(ra), 20972, 14);
      ex = longint'(c.player_x) * 256;
      ey = longint'(c.player_y) * 256;
      travel = 0;
      hit = 0;
      for (int s = 0; s < rtc_pkg::MARCH_LIMIT; s++) begin
         ex += ddx;
         ey += ddy;
         travel += 20972;
         if (ex < 0 || ey < 0) break;
         if ((ex >> 20) >= MAP_SIZE || (ey >> 20) >= MAP_SIZE) break;
         if (map_wall(int'(ex >> 20), int'(ey >> 20))) begin
            hit = 1;
            break;
         end
      end
      corr = scale_trunc(travel, ray_sine(offset + 1647093), 14);
      if (corr < MIN_DIST) corr = MIN_DIST;
      h = hit ? (15 * Q_ONE) / corr : 0;
      if (h > rtc_pkg::SCREEN_ROWS) h = rtc_pkg::SCREEN_ROWS;
      ds = (rtc_pkg::SCREEN_ROWS - h) / 2;
      de = ds + h;
      if (travel < 3 * Q_ONE) wall_attr = rtc_pkg::ATTR_NEAR;
      else if (travel < 6 * Q_ONE) wall_attr = rtc_pkg::ATTR_MID;
      else wall_attr = rtc_pkg::ATTR_FAR;
      if (hit) hit_columns++;
      for (int r = 0; r < rtc_pkg::SCREEN_ROWS; r++) begin
         cl.row = 5'(r);
         if (r < ds) begin
            cl.glyph = rtc_pkg::GLYPH_CEIL;
            cl.attribute = rtc_pkg::ATTR_CEIL;
         end else if (r < de) begin
            cl.glyph = rtc_pkg::GLYPH_WALL;
            cl.attribute = wall_attr;
         end else begin
            cl.glyph = rtc_pkg::GLYPH_FLOOR;
            cl.attribute = rtc_pkg::ATTR_FLOOR;
         end
         cl.wall_hit = hit;
         cl.last_cell = (r == rtc_pkg::SCREEN_ROWS - 1);
         expected_cells.push_back(cl);
      end
   endtask

   // Driver: one word per handshake, random gap before each.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         cast_column(pending_cols.pop_front());
         cols_sent++;
         req_tvalid <= 1'b0;
         send_gap <= $urandom_range(0, 8);
      end else if (!req_tvalid && send_gap > 0) begin
         send_gap <= send_gap - 1;
      end else if (!req_tvalid && pending_cols.size() > 0) begin
         req_tdata <= {1'b0, pending_cols[0].view_angle, pending_cols[0].player_y,
                       pending_cols[0].player_x, pending_cols[0].column};
         req_tvalid <= 1'b1;
      end
   end

   // Monitor: compare each cell with the oldest expectation.
   int stall = 0;
   always @(posedge clock) begin
      cell_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            cells_seen++;
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected cell, actual %h last %b", $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata[4:0] !== want.row || rsp_tdata[6:5] !== want.glyph ||
                   rsp_tdata[14:7] !== want.attribute || rsp_tdata[15] !== want.wall_hit ||
                   rsp_tlast !== want.last_cell) begin
                  $display("%0t: cell mismatch, expected row %0d glyph %0d attr %h hit %b last %b,",
                           $time, want.row, want.glyph, want.attribute, want.wall_hit,
                           want.last_cell);
                  $display("%0t:   actual row %0d glyph %0d attr %h hit %b last %b", $time,
                           rsp_tdata[4:0], rsp_tdata[6:5], rsp_tdata[14:7], rsp_tdata[15],
                           rsp_tlast);
                  error_count++;
               end
            end
            stall = $urandom_range(0, 8);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(int idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 5'(idx * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      wall_map[idx] = value;
   endtask

   task automatic queue_column(logic [6:0] col, logic [15:0] px, logic [15:0] py,
                               logic [15:0] ang);
      column_req_type c;
      c.column = col;
      c.player_x = px;
      c.player_y = py;
      c.view_angle = ang;
      pending_cols.push_back(c);
   endtask

   // Wait until the block has drained, then a margin for trailing work.
   task automatic drain();
      wait (pending_cols.size() == 0 && !req_tvalid && expected_cells.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_columns(int n);
      for (int i = 0; i < n; i++) begin
         // Mostly positions inside the map; now and then any value or column.
         if ($urandom_range(0, 9) == 0)
            queue_column(7'($urandom_range(0, 127)), 16'($urandom), 16'($urandom),
                         16'($urandom));
         else
            queue_column(7'($urandom_range(0, 79)), 16'($urandom_range(4096, 61439)),
                         16'($urandom_range(4096, 61439)), 16'($urandom));
      end
   endtask

   // Border of walls with random inner blocks.
   function automatic void make_room(output logic [63:0] regs[4], input int density);
      logic [15:0] row_bits;
      for (int r = 0; r < 16; r++) begin
         row_bits = (r == 0 || r == 15) ? 16'hFFFF : 16'h8001;
         for (int x = 1; x < 15; x++)
            if ($urandom_range(0, 99) < density) row_bits[x] = 1'b1;
         regs[r >> 2][(r & 3) * 16 +: 16] = row_bits;
      end
   endfunction

   initial begin
      logic [63:0] room[4];
      for (int i = 0; i < 4; i++) wall_map[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty map: every ray leaves the map or runs out of steps.
      queue_column(0, 16'h8000, 16'h8000, 16'h0000);
      queue_column(79, 16'h8000, 16'h8000, 16'h7FFF);
      queue_column(127, 16'h0000, 16'h0000, 16'h8000);
      queue_column(40, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_column(40, 16'h0000, 16'h8000, 16'h3244);
      drain();

      // Full map: hit at the first step, height capped.
      for (int i = 0; i < 4; i++) csr_write(i, '1);
      queue_column(0, 16'h8000, 16'h8000, 16'h0000);
      queue_column(79, 16'h1800, 16'h1800, 16'hCDBC);
      queue_column(100, 16'hF000, 16'h1000, 16'h1000);
      drain();

      // Border room: near, mid and far walls, several directions.
      make_room(room, 0);
      for (int i = 0; i < 4; i++) csr_write(i, room[i]);
      queue_column(40, 16'h1800, 16'h8000, 16'h0000);
      queue_column(40, 16'h4800, 16'h8000, 16'h0000);
      queue_column(40, 16'h1800, 16'h8000, 16'h8000);
      queue_column(0, 16'h1800, 16'h1800, 16'h0C90);
      queue_column(79, 16'hE800, 16'hE800, 16'hF370);
      queue_column(20, 16'h8000, 16'h8000, 16'h1922);
      queue_column(60, 16'h8000, 16'h8000, 16'hE6DE);
      // Hold back until the room columns have all come out.
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         make_room(room, 5 + phase * 10);
         if (phase == 3) room[3] = 64'($urandom);
         for (int i = 0; i < 4; i++) csr_write(i, room[i]);
         random_columns(40);
         drain();
      end
      csr_write(0, '0);
      random_columns(10);
      drain();

      $display("Covered %0d columns (%0d with a wall hit), %0d cells checked,",
               cols_sent, hit_columns, cells_seen);
      $display("over empty, full, border-only and randomly filled wall maps.");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d cells still expected", expected_cells.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
